@@ design/bmp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types, field codes and format tables of the manifest parser.
// ----------------------------------------------------------------------------
package bmp_pkg;

    // field codes, also used as the parser phase
    localparam logic [4:0] F_VERSION        = 5'd0;
    localparam logic [4:0] F_CODEC_LEN      = 5'd3;
    localparam logic [4:0] F_CODEC_BYTE     = 5'd4;
    localparam logic [4:0] F_DIGEST_LEN     = 5'd5;
    localparam logic [4:0] F_DIGEST_BYTE    = 5'd6;
    localparam logic [4:0] F_HAS_HEADER     = 5'd7;
    localparam logic [4:0] F_VOL_X          = 5'd8;
    localparam logic [4:0] F_CHUNK_COUNT    = 5'd15;
    localparam logic [4:0] F_CHUNK_DIG_LEN  = 5'd16;
    localparam logic [4:0] F_CHUNK_DIG_BYTE = 5'd17;
    localparam logic [4:0] F_CHUNK_STORED   = 5'd18;
    localparam logic [4:0] F_ELEM_END       = 5'd27;
    localparam logic [4:0] CODE_STATUS      = 5'd28;
    localparam logic [4:0] PH_MAGIC         = 5'd28;

    // parse status codes
    localparam logic [2:0] ST_PROGRESS    = 3'd0;
    localparam logic [2:0] ST_COMPLETE    = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_TRUNCATED   = 3'd4;

    // outcome latch codes
    localparam logic [1:0] OUT_PARSING     = 2'd0;
    localparam logic [1:0] OUT_COMPLETE    = 2'd1;
    localparam logic [1:0] OUT_BAD_MAGIC   = 2'd2;
    localparam logic [1:0] OUT_BAD_VERSION = 2'd3;

    typedef struct packed {
        logic [4:0]  code;
        logic [63:0] value;
        logic [31:0] recnum;
        logic [2:0]  status;
    } t_rec;

    // what one input byte leaves for the back end
    typedef struct packed {
        logic has_rec;
        logic has_trunc;
        t_rec rec;
    } t_bundle;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h43;
            2'd1:    b = 8'h56;
            2'd2:    b = 8'h42;
            default: b = 8'h31;
        endcase
        return b;
    endfunction

    // byte length of each fixed field
    function automatic logic [3:0] field_len(input logic [4:0] code);
        logic [3:0] n;
        case (code)
            5'd0, 5'd1, 5'd3, 5'd5, 5'd11, 5'd15, 5'd16, 5'd18, 5'd25: n = 4'd4;
            5'd4, 5'd6, 5'd7, 5'd17:                                   n = 4'd1;
            default:                                                   n = 4'd8;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

@@ design/brick_manifest_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brick_manifest_parser
// Streaming byte decoder for brick manifest messages, one record per field.
// ----------------------------------------------------------------------------
// Takes one manifest byte per cycle while o_stall is low and gives one record
// per decoded field or string byte, plus a status-only record on an error or
// truncation. The parser updates its state on every accepted byte, so input
// runs at one byte a cycle while o_stall is low; a byte that ends a message
// early while a field completes yields two records, and the output register
// moves one record a cycle while i_stall is low. A queue of QUEUE_DEPTH record
// bundles lets the input carry on while the output is stalled; o_stall rises
// only when that queue is full; records go through the queue to the output.
module brick_manifest_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_field_code,
    output logic [63:0]      o_field_value,
    output logic [31:0]      o_record_number,
    output logic [2:0]       o_parse_status,
    output logic             o_final_of_run
);

    bmp_pkg::t_bundle push_data;
    bmp_pkg::t_bundle head;
    bmp_pkg::t_rec    out_rec;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    logic             accept;

    assign accept  = i_valid && !full;
    assign o_stall = full;

    bmp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_bundle         (push_data),
        .o_push           (push)
    );

    bmp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head),
        .o_empty (empty)
    );

    bmp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rec   (out_rec),
        .o_final (o_final_of_run)
    );

    assign o_field_code    = out_rec.code;
    assign o_field_value   = out_rec.value;
    assign o_record_number = out_rec.recnum;
    assign o_parse_status  = out_rec.status;

endmodule
`default_nettype wire

@@ design/bmp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_front
// Parser state machine: takes one byte a cycle when accepted and classifies it
// into at most one field or status record plus an optional truncation record.
// ----------------------------------------------------------------------------
module bmp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_end_of_message,
    output bmp_pkg::t_bundle     o_bundle,
    output logic                 o_push
);

    logic [4:0]  r_phase,   n_phase;
    logic [2:0]  r_bp,      n_bp;
    logic [63:0] r_acc,     n_acc;
    logic [31:0] r_left,    n_left;
    logic [31:0] r_total,   n_total;
    logic [31:0] r_cnt,     n_cnt;
    logic        r_hdr,     n_hdr;
    logic [1:0]  r_outcome, n_outcome;

    bmp_pkg::t_bundle bundle;

    always_comb begin
        logic [3:0]  len;
        logic [63:0] acc_or;
        logic [2:0]  bp_inc;
        logic        fin;
        logic [63:0] fin_v;
        logic [31:0] left_dec;
        logic [31:0] cnt_inc;

        n_phase   = r_phase;
        n_bp      = r_bp;
        n_acc     = r_acc;
        n_left    = r_left;
        n_total   = r_total;
        n_cnt     = r_cnt;
        n_hdr     = r_hdr;
        n_outcome = r_outcome;

        bundle            = '0;
        fin               = 1'b0;
        fin_v             = '0;
        len               = bmp_pkg::field_len(r_phase);
        acc_or            = r_acc | ({56'd0, i_data_byte} << {r_bp, 3'b000});
        bp_inc            = r_bp + 3'd1;
        left_dec          = r_left - 32'd1;
        cnt_inc           = r_cnt + 32'd1;

        if (r_outcome == bmp_pkg::OUT_PARSING) begin
            if (r_phase >= bmp_pkg::PH_MAGIC) begin
                if (i_data_byte != bmp_pkg::magic_byte(r_bp[1:0])) begin
                    n_outcome          = bmp_pkg::OUT_BAD_MAGIC;
                    bundle.has_rec     = 1'b1;
                    bundle.rec.code    = bmp_pkg::CODE_STATUS;
                    bundle.rec.status  = bmp_pkg::ST_BAD_MAGIC;
                end else if (r_bp == 3'd3) begin
                    n_bp    = '0;
                    n_phase = bmp_pkg::F_VERSION;
                end else begin
                    n_bp = bp_inc;
                end
            end else if (len == 4'd1) begin
                fin   = 1'b1;
                fin_v = {56'd0, i_data_byte};
            end else if (bp_inc == len[2:0]) begin
                fin   = 1'b1;
                fin_v = acc_or;
                n_bp  = '0;
                n_acc = '0;
            end else begin
                n_acc = acc_or;
                n_bp  = bp_inc;
            end
        end

        if (fin) begin
            bundle.has_rec    = 1'b1;
            bundle.rec.code   = r_phase;
            bundle.rec.value  = fin_v;
            bundle.rec.recnum = (r_phase >= bmp_pkg::F_CHUNK_DIG_LEN) ? r_cnt : 32'd0;
            bundle.rec.status = bmp_pkg::ST_PROGRESS;
            case (r_phase)
                bmp_pkg::F_VERSION: begin
                    if (fin_v != 64'd1) begin
                        // bad version: status-only record carrying the version
                        n_outcome         = bmp_pkg::OUT_BAD_VERSION;
                        bundle.rec.code   = bmp_pkg::CODE_STATUS;
                        bundle.rec.status = bmp_pkg::ST_BAD_VERSION;
                    end else begin
                        n_phase = r_phase + 5'd1;
                    end
                end
                bmp_pkg::F_CODEC_LEN, bmp_pkg::F_DIGEST_LEN, bmp_pkg::F_CHUNK_DIG_LEN: begin
                    n_left  = fin_v[31:0];
                    // empty string skips the byte phase
                    n_phase = (fin_v[31:0] == 32'd0) ? r_phase + 5'd2 : r_phase + 5'd1;
                end
                bmp_pkg::F_CODEC_BYTE, bmp_pkg::F_DIGEST_BYTE,
                bmp_pkg::F_CHUNK_DIG_BYTE: begin
                    n_left = left_dec;
                    if (left_dec == 32'd0) begin
                        n_phase = r_phase + 5'd1;
                    end
                end
                bmp_pkg::F_HAS_HEADER: begin
                    n_hdr            = (fin_v != 64'd0);
                    bundle.rec.value = {63'd0, n_hdr};
                    n_phase          = n_hdr ? bmp_pkg::F_VOL_X : bmp_pkg::F_CHUNK_COUNT;
                end
                bmp_pkg::F_CHUNK_COUNT: begin
                    n_total = fin_v[31:0];
                    n_cnt   = '0;
                    if (fin_v[31:0] == 32'd0) begin
                        n_outcome         = bmp_pkg::OUT_COMPLETE;
                        bundle.rec.status = bmp_pkg::ST_COMPLETE;
                    end else begin
                        n_phase = bmp_pkg::F_CHUNK_DIG_LEN;
                    end
                end
                bmp_pkg::F_ELEM_END: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc == r_total) begin
                        n_outcome         = bmp_pkg::OUT_COMPLETE;
                        bundle.rec.status = bmp_pkg::ST_COMPLETE;
                    end else begin
                        n_phase = bmp_pkg::F_CHUNK_DIG_LEN;
                    end
                end
                default: begin
                    n_phase = r_phase + 5'd1;
                end
            endcase
        end

        bundle.has_trunc = i_end_of_message && (n_outcome == bmp_pkg::OUT_PARSING);

        if (i_end_of_message) begin
            n_phase   = bmp_pkg::PH_MAGIC;
            n_bp      = '0;
            n_acc     = '0;
            n_left    = '0;
            n_total   = '0;
            n_cnt     = '0;
            n_hdr     = 1'b0;
            n_outcome = bmp_pkg::OUT_PARSING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bmp_pkg::PH_MAGIC;
            r_bp      <= '0;
            r_acc     <= '0;
            r_left    <= '0;
            r_total   <= '0;
            r_cnt     <= '0;
            r_hdr     <= 1'b0;
            r_outcome <= bmp_pkg::OUT_PARSING;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_bp      <= n_bp;
            r_acc     <= n_acc;
            r_left    <= n_left;
            r_total   <= n_total;
            r_cnt     <= n_cnt;
            r_hdr     <= n_hdr;
            r_outcome <= n_outcome;
        end
    end

    assign o_bundle = bundle;
    assign o_push   = i_accept && (bundle.has_rec || bundle.has_trunc);

endmodule
`default_nettype wire

@@ design/bmp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_queue
// Small register FIFO of record bundles between parser and output stage.
// ----------------------------------------------------------------------------
module bmp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bmp_pkg::t_bundle i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output bmp_pkg::t_bundle      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bmp_pkg::t_bundle r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ design/bmp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_back
// Output stage: unpacks each bundle into one or two records and holds the
// current record in an output register under the stall handshake.
// ----------------------------------------------------------------------------
module bmp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bmp_pkg::t_bundle i_head,
    input  wire logic             i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output bmp_pkg::t_rec         o_rec,
    output logic                  o_final
);

    logic          r_valid;
    logic          r_pend;
    logic          r_final;
    bmp_pkg::t_rec r_rec;

    logic          take;
    logic          first_of_two;
    bmp_pkg::t_rec trunc_rec;

    assign take         = !r_valid || !i_stall;
    // field record still to go out ahead of the truncation record
    assign first_of_two = i_head.has_rec && !r_pend && i_head.has_trunc;
    assign o_pop        = take && !i_empty && !first_of_two;

    always_comb begin
        trunc_rec        = '0;
        trunc_rec.code   = bmp_pkg::CODE_STATUS;
        trunc_rec.status = bmp_pkg::ST_TRUNCATED;
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_empty) begin
            if (i_head.has_rec && !r_pend) begin
                r_rec   <= i_head.rec;
                r_final <= !i_head.has_trunc;
            end else begin
                r_rec   <= trunc_rec;
                r_final <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (take) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_pend <= first_of_two;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;
    assign o_final = r_final;

endmodule
`default_nettype wire
